@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers shared by the cache directory RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ rtl/core/sacd_pkg.sv @@
// ----------------------------------------------------------------------------
// sacd_pkg
// Types, geometry constants and LRU helpers of the cache directory.
// ----------------------------------------------------------------------------
package sacd_pkg;

  localparam int SET_BITS   = 6;
  localparam int WAYS       = 4;
  localparam int BLOCK_BITS = 6;
  localparam int ADDR_BITS  = 24;
  localparam int TAG_BITS   = ADDR_BITS - SET_BITS - BLOCK_BITS;
  localparam int WAY_BITS   = $clog2(WAYS);
  localparam int NUM_SETS   = 1 << SET_BITS;

  typedef logic [WAYS-1:0][TAG_BITS-1:0] tag_row_t;
  typedef logic [WAYS-1:0][WAY_BITS-1:0] lru_row_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] address;
    logic                 is_write;
  } req_t;

  typedef struct packed {
    logic                  hit;
    logic [SET_BITS-1:0]   set_index;
    logic [WAY_BITS-1:0]   way;
    logic [BLOCK_BITS-1:0] byte_offset;
    logic                  writeback_valid;
    logic [ADDR_BITS-1:0]  writeback_address;
    logic                  fill_valid;
    logic [ADDR_BITS-1:0]  fill_address;
  } rsp_t;

  typedef struct packed {
    tag_row_t       tag_row;
    lru_row_t       lru_row;
    logic [WAYS-1:0] valid_row;
    logic [WAYS-1:0] dirty_row;
  } upd_t;

  typedef struct packed {
    tag_row_t        tag_row;
    logic [WAYS-1:0] valid_row;
    logic [WAYS-1:0] dirty_row;
  } dir_row_t;

  typedef struct packed {
    logic                en;
    logic [SET_BITS-1:0] addr;
    dir_row_t            data;
  } tag_wr_t;

  typedef struct packed {
    logic                en;
    logic [SET_BITS-1:0] addr;
    lru_row_t            data;
  } lru_wr_t;

  function automatic lru_row_t lru_identity();
    lru_row_t r;
    for (int i = 0; i < WAYS; i++) begin
      r[i] = WAY_BITS'(i);
    end
    return r;
  endfunction

  // Entry 0 is least recent; move w to the most recent end.
  function automatic lru_row_t lru_touch(lru_row_t row, logic [WAY_BITS-1:0] w);
    lru_row_t nr;
    logic     seen;
    seen = 1'b0;
    for (int j = 0; j < WAYS - 1; j++) begin
      if (row[j] == w) begin
        seen = 1'b1;
      end
      nr[j] = seen ? row[j+1] : row[j];
    end
    nr[WAYS-1] = w;
    return nr;
  endfunction

endpackage

@@ rtl/core/set_assoc_lru_cache_directory.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_directory
// Tag directory of a 4-way, 64-set write-back cache with true LRU.
// ----------------------------------------------------------------------------
// A request is taken on every clock with start high while busy is low; busy
// is high only during reset. A request is held in the s1 registers; its result
// is then registered, shown for a single cycle with done high. The receiver must
// take it then, since nothing can hold it. The tag and LRU memories are read
// in the accept cycle and written back in the next, so one request per cycle
// is sustained; back-to-back requests to the same set are forwarded.
module set_assoc_lru_cache_directory (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  sacd_pkg::req_t request,
  output logic           done,
  output sacd_pkg::rsp_t result
);
  import sacd_pkg::*;
`include "assert_macros.svh"

  logic                                accept;
  logic                                s1_valid;
  req_t                                s1_req;
  logic [SET_BITS-1:0]                 s1_set;
  logic [SET_BITS-1:0]                 in_set;
  dir_row_t                            dir_rd;
  lru_row_t                            lru_rd;
  dir_row_t                            fwd_dir;
  lru_row_t                            fwd_lru;
  logic                                fwd_hit;
  dir_row_t                            dir_use;
  lru_row_t                            lru_use;
  dir_row_t                            dir_new;
  rsp_t                                rsp;
  upd_t                                upd;
  tag_wr_t                             tag_wr;
  lru_wr_t                             lru_wr;

  assign busy   = rst;
  assign accept = start && !busy;
  assign in_set = request.address[BLOCK_BITS +: SET_BITS];
  assign s1_set = s1_req.address[BLOCK_BITS +: SET_BITS];

  assign dir_new = '{tag_row: upd.tag_row, valid_row: upd.valid_row,
                     dirty_row: upd.dirty_row};

  assign tag_wr.en   = s1_valid;
  assign tag_wr.addr = s1_set;
  assign tag_wr.data = dir_new;
  assign lru_wr.en   = s1_valid;
  assign lru_wr.addr = s1_set;
  assign lru_wr.data = upd.lru_row;

  sacd_tag_ram u_tag_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (in_set),
    .rd_data (dir_rd),
    .wr      (tag_wr)
  );

  sacd_lru_ram u_lru_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (in_set),
    .rd_data (lru_rd),
    .wr      (lru_wr)
  );

  assign dir_use = fwd_hit ? fwd_dir : dir_rd;
  assign lru_use = fwd_hit ? fwd_lru : lru_rd;

  sacd_lookup u_lookup (
    .req       (s1_req),
    .tag_row   (dir_use.tag_row),
    .lru_row   (lru_use),
    .valid_row (dir_use.valid_row),
    .dirty_row (dir_use.dirty_row),
    .rsp       (rsp),
    .upd       (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= accept;
      fwd_hit  <= accept && s1_valid && (in_set == s1_set);
      done     <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req <= request;
    end
    fwd_dir <= dir_new;
    fwd_lru <= upd.lru_row;
    result  <= rsp;
  end

  `ASSERT_RST(a_hit_or_fill, clk, rst, done |-> (result.hit != result.fill_valid), "hit and fill disagree")
  `ASSERT_RST(a_wb_on_miss, clk, rst, (done && result.writeback_valid) |-> result.fill_valid, "write-back without a miss")
  `ASSERT_RST(a_result_follows, clk, rst, s1_valid |=> done, "request lost between stages")
  `ASSERT_RST(a_way_valid, clk, rst, s1_valid |-> upd.valid_row[rsp.way], "result way not valid")
  `ASSERT_ALWAYS(a_busy_reset, clk, busy == rst, "busy outside reset")

endmodule

@@ rtl/core/sacd_tag_ram.sv @@
// ----------------------------------------------------------------------------
// sacd_tag_ram
// Tag, valid and dirty memory, one row of all ways per set, registered read;
// per-row init bits make unwritten rows read as all invalid and clean.
// ----------------------------------------------------------------------------
module sacd_tag_ram (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [sacd_pkg::SET_BITS-1:0] rd_addr,
  output sacd_pkg::dir_row_t            rd_data,
  input  sacd_pkg::tag_wr_t             wr
);
  import sacd_pkg::*;

  dir_row_t            mem [NUM_SETS];
  logic [NUM_SETS-1:0] row_init;
  dir_row_t            rd_raw;
  logic                rd_init;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_raw <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_init <= '0;
      rd_init  <= 1'b0;
    end else begin
      if (wr.en) begin
        row_init[wr.addr] <= 1'b1;
      end
      rd_init <= row_init[rd_addr];
    end
  end

  assign rd_data = rd_init ? rd_raw : '0;

endmodule

@@ rtl/core/sacd_lru_ram.sv @@
// ----------------------------------------------------------------------------
// sacd_lru_ram
// LRU order memory with per-row init bits; unwritten rows read as identity.
// ----------------------------------------------------------------------------
module sacd_lru_ram (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [sacd_pkg::SET_BITS-1:0] rd_addr,
  output sacd_pkg::lru_row_t            rd_data,
  input  sacd_pkg::lru_wr_t             wr
);
  import sacd_pkg::*;

  lru_row_t            mem [NUM_SETS];
  logic [NUM_SETS-1:0] row_init;
  lru_row_t            rd_raw;
  logic                rd_init;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_raw <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_init <= '0;
      rd_init  <= 1'b0;
    end else begin
      if (wr.en) begin
        row_init[wr.addr] <= 1'b1;
      end
      rd_init <= row_init[rd_addr];
    end
  end

  assign rd_data = rd_init ? rd_raw : lru_identity();

endmodule

@@ rtl/core/sacd_lookup.sv @@
// ----------------------------------------------------------------------------
// sacd_lookup
// Tag compare, victim choice, result fields and new set state.
// ----------------------------------------------------------------------------
module sacd_lookup (
  input  sacd_pkg::req_t              req,
  input  sacd_pkg::tag_row_t          tag_row,
  input  sacd_pkg::lru_row_t          lru_row,
  input  logic [sacd_pkg::WAYS-1:0]   valid_row,
  input  logic [sacd_pkg::WAYS-1:0]   dirty_row,
  output sacd_pkg::rsp_t              rsp,
  output sacd_pkg::upd_t              upd
);
  import sacd_pkg::*;

  logic [TAG_BITS-1:0]   tag;
  logic [SET_BITS-1:0]   set;
  logic                  found;
  logic [WAY_BITS-1:0]   hit_way;
  logic [WAY_BITS-1:0]   victim;
  logic [WAY_BITS-1:0]   way;

  assign tag    = req.address[ADDR_BITS-1 -: TAG_BITS];
  assign set    = req.address[BLOCK_BITS +: SET_BITS];
  assign victim = lru_row[0];
  assign way    = found ? hit_way : victim;

  always_comb begin
    found   = 1'b0;
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (valid_row[w] && tag_row[w] == tag) begin
        found   = 1'b1;
        hit_way = WAY_BITS'(w);
      end
    end
  end

  always_comb begin
    rsp                   = '0;
    rsp.hit               = found;
    rsp.set_index         = set;
    rsp.way               = way;
    rsp.byte_offset       = req.address[BLOCK_BITS-1:0];
    upd.tag_row           = tag_row;
    upd.valid_row         = valid_row;
    upd.dirty_row         = dirty_row;
    upd.lru_row           = lru_touch(lru_row, way);
    if (found) begin
      if (req.is_write) begin
        upd.dirty_row[hit_way] = 1'b1;
      end
    end else begin
      if (valid_row[victim] && dirty_row[victim]) begin
        rsp.writeback_valid   = 1'b1;
        rsp.writeback_address = {tag_row[victim], set, {BLOCK_BITS{1'b0}}};
      end
      rsp.fill_valid          = 1'b1;
      rsp.fill_address        = {req.address[ADDR_BITS-1:BLOCK_BITS], {BLOCK_BITS{1'b0}}};
      upd.tag_row[victim]     = tag;
      upd.valid_row[victim]   = 1'b1;
      upd.dirty_row[victim]   = req.is_write;
    end
  end

endmodule
